// File: design/sru_pkg.sv
`timescale 1ns / 1ps

package sru_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 4;
  localparam int COLUMNS    = 256;
  localparam int COL_AW     = $clog2(COLUMNS);
  localparam int COL_WIDTH  = 8;
  localparam int TABLE_SIZE = 512;
  localparam int TABLE_HALF = TABLE_SIZE / 2;
  localparam int TABLE_AW   = $clog2(TABLE_SIZE);
  localparam int ROM_AW     = TABLE_AW + 1;
  localparam int IDX_SHIFT  = DATA_WIDTH - TABLE_AW;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int SHIFT_WIDTH = PROD_WIDTH - FRAC_BITS;

  localparam longint unsigned Q62_ONE = 64'd1 << 62;
  localparam longint unsigned LO_MASK = 64'hFFFF_FFFF;

  typedef logic signed [DATA_WIDTH-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  localparam logic BANK_SIGMOID = 1'b0;
  localparam logic BANK_TANH    = 1'b1;

  typedef struct packed {
    logic [COL_WIDTH-1:0] column;
    logic                 first_step;
    sample_t              init_cell;
    sample_t              candidate;
    sample_t              forget_pre;
    sample_t              reset_pre;
    sample_t              bias_forget;
    sample_t              bias_reset;
    sample_t              highway_x;
    sample_t              drop_mask;
  } sru_in_t;

  typedef struct packed {
    logic [COL_WIDTH-1:0] out_column;
    sample_t              cell_state;
    sample_t              hidden_out;
  } sru_out_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FSUM,
    ST_RSUM,
    ST_DIFF,
    ST_MULF,
    ST_CADD,
    ST_MULM,
    ST_SUBX,
    ST_MULR,
    ST_HADD
  } state_t;

  typedef logic [DATA_WIDTH-1:0] gate_rom_t [0:2*TABLE_SIZE-1];

  // Restoring long division, evaluated only while the gate table is built.
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo, rem;
    int b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Bank 0 holds the sigmoid, bank 1 the hyperbolic tangent. Entry i stands for
  // the argument (i - TABLE_HALF) / 32, rounded to nearest at FRAC_BITS.
  function automatic gate_rom_t build_gate_rom();
    gate_rom_t rom;
    longint unsigned en [0:2*TABLE_HALF];
    longint unsigned term, step, one, p, q, num, den, quo, rem;
    longint unsigned a0, a1, b0, b1, lo, m1, m2, hi, t, low;
    longint signed v;
    int n, i, k, a;
    term = Q62_ONE;
    step = Q62_ONE;
    for (n = 1; n <= 24; n++) begin
      term = udiv64(term, 64'(32 * n));
      if (n[0] == 1'b1) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    en[0] = Q62_ONE;
    for (i = 1; i <= 2 * TABLE_HALF; i++) begin
      a0 = en[i-1] & LO_MASK;
      a1 = en[i-1] >> 32;
      b0 = step & LO_MASK;
      b1 = step >> 32;
      lo = a0 * b0;
      m1 = a0 * b1;
      m2 = a1 * b0;
      hi = a1 * b1;
      t = (lo >> 32) + (m1 & LO_MASK) + (m2 & LO_MASK);
      low = (t << 32) | (lo & LO_MASK);
      hi = hi + (m1 >> 32) + (m2 >> 32) + (t >> 32);
      en[i] = (hi << 2) | (low >> 62);
    end
    one = Q62_ONE >> FRAC_BITS;
    for (i = 0; i < TABLE_SIZE; i++) begin
      k = i - TABLE_HALF;
      a = (k < 0) ? -k : k;
      p = en[a] >> FRAC_BITS;
      num = (k >= 0) ? (one << FRAC_BITS) : (p << FRAC_BITS);
      den = one + p;
      quo = udiv64(num, den);
      rem = num - quo * den;
      if (rem >= den - rem) begin
        quo = quo + 64'd1;
      end
      rom[i] = DATA_WIDTH'(quo);
      q = en[2*a] >> FRAC_BITS;
      num = (one - q) << FRAC_BITS;
      den = one + q;
      quo = udiv64(num, den);
      rem = num - quo * den;
      if (rem >= den - rem) begin
        quo = quo + 64'd1;
      end
      v = signed'(quo);
      if (k < 0) begin
        v = -v;
      end
      rom[TABLE_SIZE + i] = DATA_WIDTH'(v);
    end
    return rom;
  endfunction

  localparam gate_rom_t GATE_ROM = build_gate_rom();

endpackage

// File: design/sru_in_if.sv
`timescale 1ns / 1ps

interface sru_in_if import sru_pkg::*; ;
  logic    valid;
  logic    ready;
  sru_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/sru_out_if.sv
`timescale 1ns / 1ps

interface sru_out_if import sru_pkg::*; ;
  logic     valid;
  logic     ready;
  sru_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/sru_alu.sv
`timescale 1ns / 1ps

module sru_alu import sru_pkg::*; (
  input  alu_ctl_t ctl,
  input  sample_t  a,
  input  sample_t  b,
  output sample_t  y
);

  logic signed [DATA_WIDTH:0]    sum;
  logic signed [PROD_WIDTH-1:0]  prod;
  logic signed [SHIFT_WIDTH-1:0] scaled;
  logic                          scaled_fits;

  assign prod   = a * b;
  assign scaled = prod[PROD_WIDTH-1:FRAC_BITS];
  assign scaled_fits = (&scaled[SHIFT_WIDTH-1:DATA_WIDTH-1]) |
                       (~|scaled[SHIFT_WIDTH-1:DATA_WIDTH-1]);

  always_comb begin
    if (ctl.op == OP_SUB) begin
      sum = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    end else begin
      sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    end
  end

  always_comb begin
    unique case (ctl.op)
      OP_ADD, OP_SUB: begin
        if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
          y = sum[DATA_WIDTH] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
          y = sum[DATA_WIDTH-1:0];
        end
      end
      OP_MUL: begin
        if (!scaled_fits) begin
          y = scaled[SHIFT_WIDTH-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
          y = scaled[DATA_WIDTH-1:0];
        end
      end
      default: y = sum[DATA_WIDTH-1:0];
    endcase
  end

endmodule

// File: design/sru_cell_recurrence.sv
`timescale 1ns / 1ps

// Channel   Role    Payload
// item      sink    column, first_step, init_cell, gate inputs, highway_x, drop_mask
// result    source  out_column, cell_state, hidden_out
//
// Transactions are handled one at a time: one saturating adder/multiplier is used
// nine times in turn, and the gate table has a single registered read port.
// The next item is taken once the sequencer is back in idle, even while the
// previous result still waits in the output register.
// A stalled result holds the sequencer in its last step until the register frees.
// Reset clears control state only; the cell store holds garbage until written.

module sru_cell_recurrence import sru_pkg::*; (
  input logic       clk,
  input logic       rst,
  sru_in_if.sink    item,
  sru_out_if.source result
);

  state_t   state;
  state_t   state_next;
  sru_in_t  job;
  sample_t  acc;
  sample_t  f_gate;
  sample_t  r_gate;
  sample_t  c_reg;
  sample_t  cell_rd;
  sample_t  rom_q;
  logic     out_valid;
  sru_out_t out_data;

  sample_t  cell_mem [0:COLUMNS-1];

  alu_ctl_t alu_ctl;
  sample_t  alu_a;
  sample_t  alu_b;
  sample_t  alu_y;
  sample_t  cprev;
  logic     rom_bank;
  logic [ROM_AW-1:0] rom_addr;
  logic     out_free;
  logic     accept;

  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;
  assign cprev    = job.first_step ? job.init_cell : cell_rd;
  assign rom_addr = {rom_bank, ~alu_y[DATA_WIDTH-1], alu_y[DATA_WIDTH-2:IDX_SHIFT]};

  assign result.valid = out_valid;
  assign result.data  = out_data;

  sru_alu u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (item.valid) state_next = ST_FSUM;
      ST_FSUM: state_next = ST_RSUM;
      ST_RSUM: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_MULF;
      ST_MULF: state_next = ST_CADD;
      ST_CADD: state_next = ST_MULM;
      ST_MULM: state_next = ST_SUBX;
      ST_SUBX: state_next = ST_MULR;
      ST_MULR: state_next = ST_HADD;
      ST_HADD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready  = 1'b0;
    alu_ctl.op  = OP_ADD;
    alu_a       = acc;
    alu_b       = job.candidate;
    rom_bank    = BANK_SIGMOID;
    unique case (state)
      ST_IDLE: item.ready = 1'b1;
      ST_FSUM: begin
        alu_a = job.forget_pre;
        alu_b = job.bias_forget;
      end
      ST_RSUM: begin
        alu_a = job.reset_pre;
        alu_b = job.bias_reset;
      end
      ST_DIFF: begin
        alu_ctl.op = OP_SUB;
        alu_a      = cprev;
        alu_b      = job.candidate;
      end
      ST_MULF: begin
        alu_ctl.op = OP_MUL;
        alu_b      = f_gate;
      end
      ST_CADD: begin
        alu_b    = job.candidate;
        rom_bank = BANK_TANH;
      end
      ST_MULM: begin
        alu_ctl.op = OP_MUL;
        alu_a      = rom_q;
        alu_b      = job.drop_mask;
      end
      ST_SUBX: begin
        alu_ctl.op = OP_SUB;
        alu_b      = job.highway_x;
      end
      ST_MULR: begin
        alu_ctl.op = OP_MUL;
        alu_b      = r_gate;
      end
      ST_HADD: alu_b = job.highway_x;
      default: item.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_HADD && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= GATE_ROM[rom_addr];
    if (accept) begin
      job     <= item.data;
      cell_rd <= cell_mem[item.data.column[COL_AW-1:0]];
    end
    if (state == ST_RSUM) begin
      f_gate <= rom_q;
    end
    if (state == ST_DIFF) begin
      r_gate <= rom_q;
    end
    if (state == ST_DIFF || state == ST_MULF || state == ST_MULM ||
        state == ST_SUBX || state == ST_MULR) begin
      acc <= alu_y;
    end
    if (state == ST_CADD) begin
      c_reg <= alu_y;
      cell_mem[job.column[COL_AW-1:0]] <= alu_y;
    end
    if (state == ST_HADD && out_free) begin
      out_data.out_column <= job.column;
      out_data.cell_state <= c_reg;
      out_data.hidden_out <= alu_y;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_FSUM)
    else $error("accepted transaction did not start the sequence");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_HADD)
    else $error("result raised outside the final step");

  a_result_cell_matches: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HADD && out_free) |=> out_data.cell_state == c_reg)
    else $error("reported cell value differs from stored value");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> out_valid)
    else $error("pending result dropped");

endmodule

// File: tb/sv/sru_cell_recurrence_tb.sv
`timescale 1ns / 1ps

module sru_cell_recurrence_tb;
  import sru_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AFTER_ITEMS = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int DIRECTED_ROWS = 18;

  typedef struct {
    sru_in_t stim;
    bit      typed;
    sample_t cell_want;
    sample_t hidden_want;
  } directed_row_t;

  logic clk;
  logic rst;

  sru_in_if  item_ch ();
  sru_out_if result_ch ();

  sru_cell_recurrence dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  sample_t  gate_tbl [2][TABLE_SIZE];
  sample_t  cell_model [COLUMNS];
  bit       col_written [COLUMNS];
  sru_out_t expected_results [$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       items_sent = 0;
  int       burst_left = 0;

  // Rows marked typed carry a result that follows directly from the inputs.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{0, 1, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0},
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0},
    '{'{255, 1, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0}, 1, 32767, 0},
    '{'{1, 1, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0}, 1, -32768, 0},
    '{'{2, 1, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 0, 0, 0},
    '{'{3, 1, 32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768}, 0, 0, 0},
    '{'{255, 0, 0, 0, 0, 0, 0, 0, 4096, 4096}, 0, 0, 0},
    '{'{4, 1, 4096, 0, 0, 0, 0, 0, 4096, 4096}, 0, 0, 0},
    '{'{4, 0, -4096, 8192, -8192, 4096, -4096, 2048, -4096, 4096}, 0, 0, 0},
    '{'{5, 1, 8192, -8192, 16384, -16384, 16384, -16384, -2048, -4096}, 0, 0, 0},
    '{'{128, 1, -1, 1, -1, 1, -1, 1, -1, -1}, 0, 0, 0},
    '{'{127, 1, 21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846}, 0, 0, 0},
    '{'{127, 0, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845}, 0, 0, 0},
    '{'{170, 1, 255, -256, 128, -129, 32000, -32000, 1000, -1000}, 0, 0, 0},
    '{'{85, 1, -20000, 20000, -7, 7, 100, -100, -12288, 12288}, 0, 0, 0},
    '{'{0, 0, 0, 4096, -32768, 32767, 0, 0, 8191, 4096}, 0, 0, 0},
    '{'{170, 0, 0, -4096, 32767, -32768, 0, 0, -32768, 0}, 0, 0, 0},
    '{'{3, 0, 0, 12345, -12345, 300, -300, 6000, 7777, -8888}, 0, 0, 0}
  };

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic longint unsigned round_quot(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    quo = num / den;
    if (num % den >= den - num % den) begin
      quo++;
    end
    return quo;
  endfunction

  function automatic sample_t clamp_q(longint v);
    if (v > longint'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end
    if (v < longint'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return sample_t'(v);
  endfunction

  function automatic sample_t mul_q(sample_t a, sample_t b);
    return clamp_q((longint'(a) * longint'(b)) >>> FRAC_BITS);
  endfunction

  function automatic sample_t gate_value(logic bank, sample_t arg);
    int idx;
    idx = (int'(arg) >>> IDX_SHIFT) + TABLE_HALF;
    return gate_tbl[bank][idx];
  endfunction

  function automatic sru_out_t sru_step_model(sru_in_t it);
    sample_t  f, r, c_prev, c, t, h;
    sru_out_t res;
    f = gate_value(BANK_SIGMOID, clamp_q(longint'(it.forget_pre) + it.bias_forget));
    r = gate_value(BANK_SIGMOID, clamp_q(longint'(it.reset_pre) + it.bias_reset));
    c_prev = it.first_step ? it.init_cell : cell_model[it.column % COLUMNS];
    c = clamp_q(longint'(mul_q(clamp_q(longint'(c_prev) - it.candidate), f)) + it.candidate);
    cell_model[it.column % COLUMNS] = c;
    t = gate_value(BANK_TANH, c);
    h = clamp_q(longint'(mul_q(clamp_q(longint'(mul_q(t, it.drop_mask)) - it.highway_x), r))
                + it.highway_x);
    res.out_column = it.column;
    res.cell_state = c;
    res.hidden_out = h;
    return res;
  endfunction

  function automatic sample_t rand_q();
    case ($urandom_range(0, 7))
      0, 1: return sample_t'($urandom_range(0, 65535));
      2: return sample_t'(int'($urandom_range(0, 3)) +
                          (($urandom_range(0, 1) != 0) ? 32764 : -32768));
      default: return sample_t'(int'($urandom_range(0, 24576)) - 12288);
    endcase
  endfunction

  function automatic sample_t rand_mask();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return sample_t'(4096);
      4: return sample_t'(0);
      default: return rand_q();
    endcase
  endfunction

  // The table entry i stands for the argument (i - TABLE_HALF) / 32, with e^(-1/32)
  // taken from its series and raised by repeated Q2.62 multiplication.
  initial begin : build_gate_tables
    longint unsigned decay [0:2*TABLE_HALF];
    longint unsigned term, step, unit, p, q;
    logic [127:0]    prod;
    longint          mag;
    int              n, i, k, a;
    term = Q62_ONE;
    step = Q62_ONE;
    for (n = 1; n <= 24; n++) begin
      term = term / 64'(32 * n);
      step = (n % 2 == 1) ? step - term : step + term;
    end
    decay[0] = Q62_ONE;
    for (i = 1; i <= 2 * TABLE_HALF; i++) begin
      prod = 128'(decay[i-1]) * 128'(step);
      decay[i] = prod[125:62];
    end
    unit = Q62_ONE >> FRAC_BITS;
    for (i = 0; i < TABLE_SIZE; i++) begin
      k = i - TABLE_HALF;
      a = (k < 0) ? -k : k;
      p = decay[a] >> FRAC_BITS;
      gate_tbl[BANK_SIGMOID][i] =
        sample_t'(round_quot((k >= 0) ? (unit << FRAC_BITS) : (p << FRAC_BITS), unit + p));
      q = decay[2*a] >> FRAC_BITS;
      mag = longint'(round_quot((unit - q) << FRAC_BITS, unit + q));
      gate_tbl[BANK_TANH][i] = sample_t'((k < 0) ? -mag : mag);
    end
  end

  task automatic send_step(input sru_in_t it, input bit typed, input sample_t cell_want,
                           input sample_t hidden_want);
    int       gap;
    sru_out_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
    want = sru_step_model(it);
    if (typed) begin
      want.cell_state = cell_want;
      want.hidden_out = hidden_want;
    end
    expected_results.push_back(want);
  endtask

  initial begin
    sru_in_t     it;
    logic [7:0]  active_cols [8];
    int          i;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      col_written[directed_rows[i].stim.column] = 1'b1;
      send_step(directed_rows[i].stim, directed_rows[i].typed,
                directed_rows[i].cell_want, directed_rows[i].hidden_want);
    end

    // Most steps revisit a few columns so that cell values chain over time.
    for (i = 0; i < 8; i++) begin
      active_cols[i] = 8'($urandom_range(0, 255));
    end
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        active_cols[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
      end
      it.column = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : active_cols[$urandom_range(0, 7)];
      it.first_step = !col_written[it.column] || ($urandom_range(0, 9) == 0);
      it.init_cell = rand_q();
      it.candidate = rand_q();
      it.forget_pre = rand_q();
      it.reset_pre = rand_q();
      it.bias_forget = rand_q();
      it.bias_reset = rand_q();
      it.highway_x = rand_q();
      it.drop_mask = rand_mask();
      col_written[it.column] = 1'b1;
      send_step(it, 1'b0, '0, '0);
    end
    item_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // The receiver switches between random stall patterns, and once holds off
  // long enough for the block to back up onto its input.
  initial begin
    int mode, mode_left;
    bit held;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_AFTER_ITEMS) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= ($urandom_range(0, 1) != 0);
        2: result_ch.ready <= ($urandom_range(0, 3) == 0);
        default: result_ch.ready <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_result
    sru_out_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction for column %0d", result_ch.data.out_column);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.data.out_column !== want.out_column) begin
          $error("out_column: expected %0d, actual %0d", want.out_column,
                 result_ch.data.out_column);
          fail_count++;
        end
        if (result_ch.data.cell_state !== want.cell_state) begin
          $error("cell_state: expected %0d, actual %0d", want.cell_state,
                 result_ch.data.cell_state);
          fail_count++;
        end
        if (result_ch.data.hidden_out !== want.hidden_out) begin
          $error("hidden_out: expected %0d, actual %0d", want.hidden_out,
                 result_ch.data.hidden_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// File: sim.f
design/sru_pkg.sv
design/sru_in_if.sv
design/sru_out_if.sv
design/sru_alu.sv
design/sru_cell_recurrence.sv
tb/sv/sru_cell_recurrence_tb.sv
